[rtl/srt_pkg.sv]
`default_nettype none
package srt_pkg;

    localparam int Capacity  = 256;
    localparam int KeyBits   = 16;
    localparam int AddrBits  = $clog2(Capacity);
    localparam int CountBits = $clog2(Capacity + 1);
    localparam int RecBits   = KeyBits + 64 + 36;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    // memory port request from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic [AddrBits-1:0] rd_addr;
        logic                wr_en;
        logic [AddrBits-1:0] wr_addr;
        logic                wr_sel_new;
    } t_mem_req;

endpackage
`default_nettype wire

[rtl/srt_store.sv]
`default_nettype none
module srt_store
    import srt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_mem_req           i_req,
    input  wire logic [RecBits-1:0] i_new_rec,
    output logic      [RecBits-1:0] o_rd_data
);
    logic [RecBits-1:0] r_mem [Capacity];

    // a shift writes back the word just read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_sel_new ? i_new_rec : o_rd_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/sorted_record_table_top.sv]
`default_nettype none
// channel | valid    | stall    | payload
// in      | i_valid  | o_stall  | i_op, i_key, i_date_bytes, i_number_a..f
// out     | o_valid  | i_stall  | o_status .. o_out_number_f
// Each item scans the record memory in key order. An insert of a new key then
// shifts larger entries up and places the record, a replace overwrites it in
// place and a remove that hits shifts entries down; a full insert does none of it.
// One item is in flight at a time; o_stall is high while it is worked on.
// Synchronous active-low reset clears the count, the sequencer and o_valid only.
// A waiting result holds until i_stall drops.
module sorted_record_table_top
    import srt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_key,
    input  wire logic [63:0] i_date_bytes,
    input  wire logic [5:0]  i_number_a,
    input  wire logic [5:0]  i_number_b,
    input  wire logic [5:0]  i_number_c,
    input  wire logic [5:0]  i_number_d,
    input  wire logic [5:0]  i_number_e,
    input  wire logic [5:0]  i_number_f,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_position,
    output logic [8:0]       o_fill_count,
    output logic [15:0]      o_out_key,
    output logic [63:0]      o_out_date,
    output logic [5:0]       o_out_number_a,
    output logic [5:0]       o_out_number_b,
    output logic [5:0]       o_out_number_c,
    output logic [5:0]       o_out_number_d,
    output logic [5:0]       o_out_number_e,
    output logic [5:0]       o_out_number_f
);
    t_state                r_state, n_state;
    logic [CountBits-1:0]  r_count, n_count;
    logic [CountBits-1:0]  r_ptr, n_ptr;
    logic [CountBits-1:0]  r_pos, n_pos;
    logic [1:0]            r_op;
    logic [RecBits-1:0]    r_new;
    logic [RecBits-1:0]    rd_data;
    t_status               r_status, n_status;
    logic                  r_found, n_found;
    logic                  r_ovalid, n_ovalid;
    t_mem_req              req;
    logic                  accept;
    logic [KeyBits-1:0]    rd_key, new_key;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign rd_key  = rd_data[RecBits-1 -: KeyBits];
    assign new_key = r_new[RecBits-1 -: KeyBits];

    srt_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .i_new_rec (r_new),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_new <= {i_key[KeyBits-1:0], i_date_bytes, i_number_f, i_number_e,
                      i_number_d, i_number_c, i_number_b, i_number_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_pos    = r_pos;
        n_status = r_status;
        n_found  = r_found;
        n_ovalid = r_ovalid && i_stall;
        req      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ptr   = '0;
                    n_found = 1'b0;
                    if (i_op == OP_INSERT && r_count == CountBits'(Capacity)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_ptr >= r_count) begin
                    // end reached without a key not smaller than the new one
                    n_pos = r_ptr;
                    if (r_op == OP_INSERT) begin
                        n_status = ST_INSERTED;
                        n_ptr    = r_count;
                        n_state  = S_SHIFT_RD;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_ptr[AddrBits-1:0];
                    n_state     = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (rd_key < new_key) begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_pos = r_ptr;
                    if (r_op == OP_INSERT) begin
                        if (rd_key == new_key) begin
                            n_status = ST_REPLACED;
                            n_ptr    = r_ptr;
                        end else begin
                            n_status = ST_INSERTED;
                            n_ptr    = r_count;
                        end
                        n_state = S_SHIFT_RD;
                    end else if (rd_key == new_key && r_op == OP_REMOVE) begin
                        n_status = ST_REMOVED;
                        n_found  = 1'b1;
                        n_ptr    = r_ptr + 1'b1;
                        n_state  = S_SHIFT_RD;
                    end else if (rd_key == new_key && r_op == OP_LOOKUP) begin
                        n_status = ST_FOUND;
                        n_found  = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (r_status == ST_REMOVED) begin
                    // move entry ptr down to ptr-1
                    if (r_ptr >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = r_ptr[AddrBits-1:0];
                        n_state     = S_SHIFT_WR;
                    end
                end else if (r_ptr == r_pos) begin
                    // place the new record
                    req.wr_en      = 1'b1;
                    req.wr_addr    = r_pos[AddrBits-1:0];
                    req.wr_sel_new = 1'b1;
                    if (r_status == ST_INSERTED) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = AddrBits'(r_ptr - 1'b1);
                    n_state     = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                req.wr_en = 1'b1;
                if (r_status == ST_REMOVED) begin
                    req.wr_addr = AddrBits'(r_ptr - 1'b1);
                    n_ptr       = r_ptr + 1'b1;
                end else begin
                    req.wr_addr = r_ptr[AddrBits-1:0];
                    n_ptr       = r_ptr - 1'b1;
                end
                n_state = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // found record is captured as it is read during the scan
    logic [RecBits-1:0] r_rec;
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN_CMP) begin
            r_rec <= rd_data;
        end
    end

    logic [RecBits-1:0] out_rec;
    assign out_rec = r_found ? r_rec : '0;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
            o_status       <= r_status;
            o_position     <= (r_status == ST_FULL || r_status == ST_NOT_FOUND)
                              ? 8'd0 : r_pos[7:0];
            o_fill_count   <= 9'(r_count);
            o_out_key      <= 16'(out_rec[RecBits-1 -: KeyBits]);
            o_out_date     <= out_rec[99:36];
            o_out_number_a <= out_rec[5:0];
            o_out_number_b <= out_rec[11:6];
            o_out_number_c <= out_rec[17:12];
            o_out_number_d <= out_rec[23:18];
            o_out_number_e <= out_rec[29:24];
            o_out_number_f <= out_rec[35:30];
        end
    end
    assign o_valid = r_ovalid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(Capacity))
        else $error("count beyond capacity");
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> r_count == CountBits'(Capacity))
        else $error("full reported below capacity");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN_CMP |-> r_ptr < r_count)
        else $error("scan read past fill");
endmodule
`default_nettype wire

[sim/sorted_record_table_checker.sv]
`timescale 1ns / 1ps
module sorted_record_table_checker
    import srt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_key,
    input  wire logic [63:0] i_date_bytes,
    input  wire logic [5:0]  i_number_a,
    input  wire logic [5:0]  i_number_b,
    input  wire logic [5:0]  i_number_c,
    input  wire logic [5:0]  i_number_d,
    input  wire logic [5:0]  i_number_e,
    input  wire logic [5:0]  i_number_f,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_status,
    input  wire logic [7:0]  i_position,
    input  wire logic [8:0]  i_fill_count,
    input  wire logic [15:0] i_out_key,
    input  wire logic [63:0] i_out_date,
    input  wire logic [5:0]  i_out_number_a,
    input  wire logic [5:0]  i_out_number_b,
    input  wire logic [5:0]  i_out_number_c,
    input  wire logic [5:0]  i_out_number_d,
    input  wire logic [5:0]  i_out_number_e,
    input  wire logic [5:0]  i_out_number_f,
    output int               o_errors,
    output int               o_pending,
    output logic [8:0]       o_fill
);

    typedef struct packed {
        logic [15:0] key;
        logic [63:0] date;
        logic [35:0] nums;
    } t_record;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  position;
        logic [8:0]  fill;
        t_record     rec;
    } t_answer;

    t_record   table_q[$];
    t_answer   answers_q[$];

    assign o_pending = answers_q.size();
    assign o_fill    = 9'(table_q.size());

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: %t %s got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic t_answer apply_op(input logic [1:0] op, input t_record rec_in);
        t_answer a;
        int      p;
        a = '0;
        a.status = ST_NOT_FOUND;
        p = 0;
        while (p < table_q.size() && table_q[p].key < rec_in.key) p++;
        if (op == OP_INSERT) begin
            if (table_q.size() >= Capacity) begin
                a.status = ST_FULL;
            end else if (p < table_q.size() && table_q[p].key == rec_in.key) begin
                table_q[p] = rec_in;
                a.status = ST_REPLACED;
                a.position = 8'(p);
            end else begin
                table_q.insert(p, rec_in);
                a.status = ST_INSERTED;
                a.position = 8'(p);
            end
        end else if (op == OP_REMOVE || op == OP_LOOKUP) begin
            if (p < table_q.size() && table_q[p].key == rec_in.key) begin
                a.rec = table_q[p];
                a.position = 8'(p);
                if (op == OP_REMOVE) begin
                    table_q.delete(p);
                    a.status = ST_REMOVED;
                end else begin
                    a.status = ST_FOUND;
                end
            end
        end
        a.fill = 9'(table_q.size());
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_record r;
        t_answer w;
        if (!i_rst_n) begin
            o_errors <= o_errors;
        end else begin
            if (i_valid && !i_in_stall) begin
                r.key  = i_key;
                r.date = i_date_bytes;
                r.nums = {i_number_f, i_number_e, i_number_d, i_number_c,
                          i_number_b, i_number_a};
                answers_q.push_back(apply_op(i_op, r));
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers_q.size() == 0) begin
                    report_mismatch("result with none expected", 0, 0);
                end else begin
                    w = answers_q.pop_front();
                    if (i_status != w.status) report_mismatch("status", i_status, w.status);
                    if (i_position != w.position)
                        report_mismatch("position", i_position, w.position);
                    if (i_fill_count != w.fill) report_mismatch("fill", i_fill_count, w.fill);
                    if (i_out_key != w.rec.key) report_mismatch("key", i_out_key, w.rec.key);
                    if (i_out_date != w.rec.date)
                        report_mismatch("date", i_out_date, w.rec.date);
                    if ({i_out_number_f, i_out_number_e, i_out_number_d, i_out_number_c,
                         i_out_number_b, i_out_number_a} != w.rec.nums)
                        report_mismatch("numbers",
                            {i_out_number_f, i_out_number_e, i_out_number_d,
                             i_out_number_c, i_out_number_b, i_out_number_a}, w.rec.nums);
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

[sim/sorted_record_table_top_test.sv]
`timescale 1ns / 1ps
module sorted_record_table_top_test;
    import srt_pkg::*;

    localparam int IdleLimit = 20000;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, out_stall = 0;
    logic [1:0]  op = OP_INSERT;
    logic [15:0] key = 0;
    logic [63:0] date = 0;
    logic [5:0]  na = 0, nb = 0, nc = 0, nd = 0, ne = 0, nf = 0;
    wire         in_stall, out_valid;
    wire  [2:0]  status;
    wire  [7:0]  position;
    wire  [8:0]  fill_count;
    wire  [15:0] out_key;
    wire  [63:0] out_date;
    wire  [5:0]  oa, ob, oc, od, oe, of_;
    int          errors, pending, idle_cycles;
    int          stall_cycle = 0;
    logic [8:0]  model_fill;
    logic        hold_off = 0;
    bit          done = 0;
    logic [15:0] used_keys[$];

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    sorted_record_table_top u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_op(op), .i_key(key), .i_date_bytes(date),
        .i_number_a(na), .i_number_b(nb), .i_number_c(nc),
        .i_number_d(nd), .i_number_e(ne), .i_number_f(nf),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status),
        .o_position(position), .o_fill_count(fill_count), .o_out_key(out_key),
        .o_out_date(out_date), .o_out_number_a(oa), .o_out_number_b(ob),
        .o_out_number_c(oc), .o_out_number_d(od), .o_out_number_e(oe),
        .o_out_number_f(of_)
    );

    sorted_record_table_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_key(key), .i_date_bytes(date),
        .i_number_a(na), .i_number_b(nb), .i_number_c(nc),
        .i_number_d(nd), .i_number_e(ne), .i_number_f(nf),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_position(position), .i_fill_count(fill_count), .i_out_key(out_key),
        .i_out_date(out_date), .i_out_number_a(oa), .i_out_number_b(ob),
        .i_out_number_c(oc), .i_out_number_d(od), .i_out_number_e(oe),
        .i_out_number_f(of_), .o_errors(errors), .o_pending(pending),
        .o_fill(model_fill)
    );

    // offer one transaction and hold it until accepted
    task automatic send(input logic [1:0] o, input logic [15:0] k, input logic [63:0] d,
                        input logic [35:0] n);
        in_valid <= 1;
        op <= o;
        key <= k;
        date <= d;
        {nf, ne, nd, nc, nb, na} <= n;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (o == OP_INSERT) used_keys.push_back(k);
    endtask

    task automatic pause(input int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly reuse known keys so remove and lookup hit
    function automatic logic [15:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return 16'($urandom);
    endfunction

    // receiver stall pattern, with one long hold-off on request
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        if (hold_off) out_stall <= 1;
        else if ((stall_cycle / 64) % 3 == 0) out_stall <= 0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        hold_off = 0;
        #1;
        wait (rst_n);
        repeat (400) @(posedge clk);
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit && !done) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int burst, kind, i;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // empty table, missing keys, unused selector, then insert, lookup, remove
        send(OP_REMOVE, 16'h0000, '0, '0);
        send(OP_LOOKUP, 16'hFFFF, '0, '0);
        send(OP_UNUSED, 16'h1234, '1, '1);
        send(OP_INSERT, 16'h8000, 64'hFFFF_FFFF_FFFF_FFFF, 36'hF_FFFF_FFFF);
        send(OP_INSERT, 16'h0000, 64'h0, 36'h0);
        send(OP_INSERT, 16'hFFFF, 64'h3130_3230_3230_3230, 36'hA_5A5A_5A5A);
        send(OP_INSERT, 16'h8000, 64'h5555_AAAA_5555_AAAA, 36'h5_A5A5_A5A5);
        send(OP_LOOKUP, 16'h8000, '0, '0);
        send(OP_LOOKUP, 16'h7FFF, '0, '0);
        send(OP_REMOVE, 16'hFFFF, '0, '0);
        send(OP_REMOVE, 16'h0000, '0, '0);
        send(OP_REMOVE, 16'h8000, '0, '0);
        send(OP_LOOKUP, 16'h8000, '0, '0);
        pause(1);
        while (pending != 0) @(posedge clk);
        // fill to capacity, then hit the full table with a replace and a new key
        i = 0;
        while (model_fill < Capacity) begin
            send(OP_INSERT, 16'(i * 200 + 7), rand64(), 36'({$urandom, $urandom}));
            i++;
            if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 20));
        end
        send(OP_INSERT, 16'd7, rand64(), '1);
        send(OP_INSERT, 16'd3, rand64(), '1);
        send(OP_LOOKUP, 16'(255 * 200 + 7), '0, '0);
        send(OP_REMOVE, 16'd7, '0, '0);
        pause(1);
        while (pending != 0) @(posedge clk);
        // random part
        i = 0;
        while (i < 1500) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                kind = $urandom_range(0, 9);
                if (kind < 5 && model_fill > 200) kind = 5;
                if (kind < 5)
                    send(OP_INSERT, pick_key(), rand64(), 36'({$urandom, $urandom}));
                else if (kind < 8)
                    send(OP_REMOVE, pick_key(), rand64(), 36'($urandom));
                else if (kind < 9)
                    send(OP_LOOKUP, pick_key(), rand64(), 36'($urandom));
                else
                    send(OP_UNUSED, 16'($urandom), rand64(), 36'($urandom));
                i++;
            end
            if ($urandom_range(0, 3) == 0) begin
                pause(1);
                while (pending != 0) @(posedge clk);
            end else begin
                pause($urandom_range(0, 40));
            end
        end
        pause(1);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        done = 1;
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

[sorted_record_table_top.f]
rtl/srt_pkg.sv
rtl/srt_store.sv
rtl/sorted_record_table_top.sv
sim/sorted_record_table_checker.sv
sim/sorted_record_table_top_test.sv
